// ----- rtl/dpbp_pkg.sv -----
// Package for the depth pixel back-projection block: constants, register indexes, shared types.
`default_nettype none
package dpbp_pkg;

  localparam int unsigned PIXEL_INDEX_BITS_DEF = 12;
  localparam int unsigned QUEUE_DEPTH          = 2;

  localparam int unsigned DEPTH_BITS  = 16;
  localparam int unsigned COLOUR_BITS = 8;
  localparam int unsigned CENTRE_BITS = 16;
  localparam int unsigned RECIP_BITS  = 32;
  localparam int unsigned Z_BITS      = 24;
  localparam int unsigned XY_BITS     = 32;
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X          = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y          = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RECIP_FOCAL_X     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RECIP_FOCAL_Y     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RECIP_DEPTH_SCALE = 3'd4;

  localparam logic [CENTRE_BITS-1:0] CENTER_X_RST          = 16'd5098;
  localparam logic [CENTRE_BITS-1:0] CENTER_Y_RST          = 16'd4085;
  localparam logic [RECIP_BITS-1:0]  RECIP_FOCAL_X_RST     = 32'd8302658;
  localparam logic [RECIP_BITS-1:0]  RECIP_FOCAL_Y_RST     = 32'd8315522;
  localparam logic [RECIP_BITS-1:0]  RECIP_DEPTH_SCALE_RST = 32'd858993;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic                      wr;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
  } cfg_wr_t;

endpackage
`default_nettype wire

// ----- rtl/depth_pixel_back_projection.sv -----
// Top level of the depth pixel back-projection block.
// Path from the start beat to the done_o strobe: a queue slot, then a
// five-stage pipeline of depth scale, rounding, offset multiply, focal multiply, round.
// Throughput: one pixel per cycle while not busy; zero-depth pixels are taken, no strobe.
// busy_o follows a full queue; the back part drains one entry every cycle.
// Reset (rst_ni, asynchronous, active low) empties the queue and pipeline and loads
// the default camera registers; configuration writes are always ready.
`default_nettype none
module depth_pixel_back_projection #(
  parameter int unsigned PIXEL_INDEX_BITS = dpbp_pkg::PIXEL_INDEX_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  output logic                                       busy_o,
  input  wire logic [dpbp_pkg::DEPTH_BITS-1:0]       depth_raw_i,
  input  wire logic [PIXEL_INDEX_BITS-1:0]           pixel_column_i,
  input  wire logic [PIXEL_INDEX_BITS-1:0]           pixel_row_i,
  input  wire logic [dpbp_pkg::COLOUR_BITS-1:0]      blue_in_i,
  input  wire logic [dpbp_pkg::COLOUR_BITS-1:0]      green_in_i,
  input  wire logic [dpbp_pkg::COLOUR_BITS-1:0]      red_in_i,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [dpbp_pkg::CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  wire logic [dpbp_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  output logic                                       done_o,
  output logic signed [dpbp_pkg::XY_BITS-1:0]        point_x_o,
  output logic signed [dpbp_pkg::XY_BITS-1:0]        point_y_o,
  output logic [dpbp_pkg::Z_BITS-1:0]                point_z_o,
  output logic [dpbp_pkg::COLOUR_BITS-1:0]           blue_out_o,
  output logic [dpbp_pkg::COLOUR_BITS-1:0]           green_out_o,
  output logic [dpbp_pkg::COLOUR_BITS-1:0]           red_out_o
);

  localparam int unsigned WIDTH = dpbp_pkg::DEPTH_BITS + 2 * PIXEL_INDEX_BITS
                                  + 3 * dpbp_pkg::COLOUR_BITS;

  dpbp_pkg::q_status_t q_status;
  dpbp_pkg::cfg_wr_t   cfg_wr;
  logic                push, pop;
  logic [WIDTH-1:0]    push_data, pop_data;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.wr    = cfg_valid_i && cfg_ready_o;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  dpbp_front #(
    .PIXEL_INDEX_BITS(PIXEL_INDEX_BITS),
    .WIDTH           (WIDTH)
  ) u_front (
    .start_i       (start_i),
    .busy_o        (busy_o),
    .depth_raw_i   (depth_raw_i),
    .pixel_column_i(pixel_column_i),
    .pixel_row_i   (pixel_row_i),
    .blue_in_i     (blue_in_i),
    .green_in_i    (green_in_i),
    .red_in_i      (red_in_i),
    .q_status_i    (q_status),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  dpbp_queue #(
    .WIDTH(WIDTH),
    .DEPTH(dpbp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .status_o   (q_status)
  );

  dpbp_back #(
    .PIXEL_INDEX_BITS(PIXEL_INDEX_BITS),
    .WIDTH           (WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_wr),
    .q_status_i (q_status),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .done_o     (done_o),
    .point_x_o  (point_x_o),
    .point_y_o  (point_y_o),
    .point_z_o  (point_z_o),
    .blue_out_o (blue_out_o),
    .green_out_o(green_out_o),
    .red_out_o  (red_out_o)
  );

endmodule
`default_nettype wire

// ----- rtl/dpbp_queue.sv -----
// Small register queue between the front and back parts.
`default_nettype none
module dpbp_queue #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = dpbp_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] pop_data_o,
  output dpbp_pkg::q_status_t   status_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign do_push = push_i && (count_q != CW'(DEPTH));
  assign do_pop  = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o     = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == CW'(DEPTH));
  assign status_o.empty = (count_q == '0);

endmodule
`default_nettype wire

// ----- rtl/dpbp_front.sv -----
// Front part: takes command beats, drops zero-depth pixels, packs the rest for the queue.
`default_nettype none
module dpbp_front #(
  parameter int unsigned PIXEL_INDEX_BITS = dpbp_pkg::PIXEL_INDEX_BITS_DEF,
  parameter int unsigned WIDTH = dpbp_pkg::DEPTH_BITS + 2 * PIXEL_INDEX_BITS
                                 + 3 * dpbp_pkg::COLOUR_BITS
) (
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic [dpbp_pkg::DEPTH_BITS-1:0]     depth_raw_i,
  input  wire logic [PIXEL_INDEX_BITS-1:0]         pixel_column_i,
  input  wire logic [PIXEL_INDEX_BITS-1:0]         pixel_row_i,
  input  wire logic [dpbp_pkg::COLOUR_BITS-1:0]    blue_in_i,
  input  wire logic [dpbp_pkg::COLOUR_BITS-1:0]    green_in_i,
  input  wire logic [dpbp_pkg::COLOUR_BITS-1:0]    red_in_i,
  input  wire dpbp_pkg::q_status_t                 q_status_i,
  output logic                                     push_o,
  output logic [WIDTH-1:0]                         push_data_o
);

  logic accept;

  assign busy_o = q_status_i.full;
  assign accept = start_i && !q_status_i.full;
  // no measurement: beat is taken but produces no point
  assign push_o = accept && (depth_raw_i != '0);
  assign push_data_o = {depth_raw_i, pixel_column_i, pixel_row_i,
                        blue_in_i, green_in_i, red_in_i};

endmodule
`default_nettype wire

// ----- rtl/dpbp_back.sv -----
// Back part: configuration registers and the five-stage projection pipeline.
`default_nettype none
module dpbp_back #(
  parameter int unsigned PIXEL_INDEX_BITS = dpbp_pkg::PIXEL_INDEX_BITS_DEF,
  parameter int unsigned WIDTH = dpbp_pkg::DEPTH_BITS + 2 * PIXEL_INDEX_BITS
                                 + 3 * dpbp_pkg::COLOUR_BITS
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire dpbp_pkg::cfg_wr_t                   cfg_i,
  input  wire dpbp_pkg::q_status_t                 q_status_i,
  input  wire logic [WIDTH-1:0]                    pop_data_i,
  output logic                                     pop_o,
  output logic                                     done_o,
  output logic signed [dpbp_pkg::XY_BITS-1:0]      point_x_o,
  output logic signed [dpbp_pkg::XY_BITS-1:0]      point_y_o,
  output logic [dpbp_pkg::Z_BITS-1:0]              point_z_o,
  output logic [dpbp_pkg::COLOUR_BITS-1:0]         blue_out_o,
  output logic [dpbp_pkg::COLOUR_BITS-1:0]         green_out_o,
  output logic [dpbp_pkg::COLOUR_BITS-1:0]         red_out_o
);

  localparam int unsigned P   = PIXEL_INDEX_BITS;
  localparam int unsigned CB  = dpbp_pkg::COLOUR_BITS;
  localparam int unsigned DB  = dpbp_pkg::DEPTH_BITS;
  localparam int unsigned RB  = dpbp_pkg::RECIP_BITS;
  localparam int unsigned ZB  = dpbp_pkg::Z_BITS;
  localparam int unsigned XB  = dpbp_pkg::XY_BITS;
  localparam int unsigned CEB = dpbp_pkg::CENTRE_BITS;
  localparam int unsigned DW  = ((P + 4 > CEB) ? P + 4 : CEB) + 1;
  localparam int unsigned MW  = DW - 1;
  localparam int unsigned ZPW = DB + RB;
  localparam int unsigned AW  = MW + ZB;
  localparam int unsigned LW  = AW + RB / 2;
  localparam int unsigned SW  = LW + 1;
  localparam int unsigned QW  = SW - 20;
  localparam int unsigned CW  = 3 * CB;

  // configuration registers
  logic [CEB-1:0] center_x_q, center_y_q;
  logic [RB-1:0]  rfx_q, rfy_q, rds_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= dpbp_pkg::CENTER_X_RST;
      center_y_q <= dpbp_pkg::CENTER_Y_RST;
      rfx_q      <= dpbp_pkg::RECIP_FOCAL_X_RST;
      rfy_q      <= dpbp_pkg::RECIP_FOCAL_Y_RST;
      rds_q      <= dpbp_pkg::RECIP_DEPTH_SCALE_RST;
    end else if (cfg_i.wr) begin
      case (cfg_i.index)
        dpbp_pkg::REG_CENTER_X:          center_x_q <= cfg_i.data[CEB-1:0];
        dpbp_pkg::REG_CENTER_Y:          center_y_q <= cfg_i.data[CEB-1:0];
        dpbp_pkg::REG_RECIP_FOCAL_X:     rfx_q      <= cfg_i.data[RB-1:0];
        dpbp_pkg::REG_RECIP_FOCAL_Y:     rfy_q      <= cfg_i.data[RB-1:0];
        dpbp_pkg::REG_RECIP_DEPTH_SCALE: rds_q      <= cfg_i.data[RB-1:0];
        default: ;
      endcase
    end
  end

  // unpack queue head
  logic [DB-1:0] in_depth;
  logic [P-1:0]  in_col, in_row;
  logic [CW-1:0] in_rgb;

  assign {in_depth, in_col, in_row, in_rgb} = pop_data_i;
  assign pop_o = !q_status_i.empty;

  // stage valids
  logic [4:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], pop_o};
    end
  end

  // stage A: depth product, pixel offsets
  logic [ZPW-1:0]       a_zp_q;
  logic signed [DW-1:0] a_dx_q, a_dy_q;
  logic [CW-1:0]        a_rgb_q;

  always_ff @(posedge clk_i) begin
    a_zp_q  <= ZPW'(in_depth) * ZPW'(rds_q);
    a_dx_q  <= $signed({{(DW-P-4){1'b0}}, in_col, 4'b0000})
             - $signed({{(DW-CEB){1'b0}}, center_x_q});
    a_dy_q  <= $signed({{(DW-P-4){1'b0}}, in_row, 4'b0000})
             - $signed({{(DW-CEB){1'b0}}, center_y_q});
    a_rgb_q <= in_rgb;
  end

  // stage B: round and clamp z, split offsets into sign and magnitude
  logic [ZPW:0]    zr;
  logic [ZPW-16:0] zs;
  logic [DW-1:0]   ndx, ndy;
  logic [ZB-1:0]   b_z_q;
  logic [MW-1:0]   b_mx_q, b_my_q;
  logic            b_nx_q, b_ny_q;
  logic [CW-1:0]   b_rgb_q;

  assign zr  = {1'b0, a_zp_q} + (ZPW+1)'(1 << 15);
  assign zs  = zr[ZPW:16];
  assign ndx = -a_dx_q;
  assign ndy = -a_dy_q;

  always_ff @(posedge clk_i) begin
    b_z_q   <= (|zs[ZPW-16:ZB]) ? {ZB{1'b1}} : zs[ZB-1:0];
    b_nx_q  <= a_dx_q[DW-1];
    b_ny_q  <= a_dy_q[DW-1];
    b_mx_q  <= a_dx_q[DW-1] ? ndx[MW-1:0] : a_dx_q[MW-1:0];
    b_my_q  <= a_dy_q[DW-1] ? ndy[MW-1:0] : a_dy_q[MW-1:0];
    b_rgb_q <= a_rgb_q;
  end

  // stage C: magnitude times z
  logic [AW-1:0] c_ax_q, c_ay_q;
  logic [ZB-1:0] c_z_q;
  logic          c_nx_q, c_ny_q;
  logic [CW-1:0] c_rgb_q;

  always_ff @(posedge clk_i) begin
    c_ax_q  <= AW'(b_mx_q) * AW'(b_z_q);
    c_ay_q  <= AW'(b_my_q) * AW'(b_z_q);
    c_z_q   <= b_z_q;
    c_nx_q  <= b_nx_q;
    c_ny_q  <= b_ny_q;
    c_rgb_q <= b_rgb_q;
  end

  // stage D: partial products with the reciprocal focal length halves
  logic [LW-1:0] d_lox_q, d_hix_q, d_loy_q, d_hiy_q;
  logic [ZB-1:0] d_z_q;
  logic          d_nx_q, d_ny_q;
  logic [CW-1:0] d_rgb_q;

  always_ff @(posedge clk_i) begin
    d_lox_q <= LW'(c_ax_q) * LW'(rfx_q[RB/2-1:0]);
    d_hix_q <= LW'(c_ax_q) * LW'(rfx_q[RB-1:RB/2]);
    d_loy_q <= LW'(c_ay_q) * LW'(rfy_q[RB/2-1:0]);
    d_hiy_q <= LW'(c_ay_q) * LW'(rfy_q[RB-1:RB/2]);
    d_z_q   <= c_z_q;
    d_nx_q  <= c_nx_q;
    d_ny_q  <= c_ny_q;
    d_rgb_q <= c_rgb_q;
  end

  // stage E: combine, round half away from zero, saturate
  function automatic logic [XB-1:0] finish(input logic [LW-1:0] lo,
                                           input logic [LW-1:0] hi,
                                           input logic          neg);
    logic [SW-1:0] s;
    logic [SW-1:0] t;
    logic [QW-1:0] q;
    logic [XB-1:0] r;
    s = SW'(lo) + SW'(64'd1 << 35);
    t = SW'(hi) + SW'(s[SW-1:16]);
    q = t[SW-1:20];
    if (neg) begin
      if (q > QW'(33'h080000000)) begin
        q = QW'(33'h080000000);
      end
      r = -q[XB-1:0];
    end else begin
      if (q > QW'(33'h07FFFFFFF)) begin
        q = QW'(33'h07FFFFFFF);
      end
      r = q[XB-1:0];
    end
    return r;
  endfunction

  logic [CW-1:0] e_rgb_q;

  always_ff @(posedge clk_i) begin
    point_x_o <= $signed(finish(d_lox_q, d_hix_q, d_nx_q));
    point_y_o <= $signed(finish(d_loy_q, d_hiy_q, d_ny_q));
    point_z_o <= d_z_q;
    e_rgb_q   <= d_rgb_q;
  end

  assign done_o = vld_q[4];
  assign {blue_out_o, green_out_o, red_out_o} = e_rgb_q;

endmodule
`default_nettype wire

// ----- rtl/dpbp_checker.sv -----
// Port-level checker for the depth pixel back-projection block, with its bind.
`default_nettype none
module dpbp_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             start_i,
  input wire logic                             busy_o,
  input wire logic [dpbp_pkg::DEPTH_BITS-1:0]  depth_raw_i,
  input wire logic [dpbp_pkg::COLOUR_BITS-1:0] blue_in_i,
  input wire logic [dpbp_pkg::COLOUR_BITS-1:0] red_in_i,
  input wire logic                             done_o,
  input wire logic [dpbp_pkg::COLOUR_BITS-1:0] blue_out_o,
  input wire logic [dpbp_pkg::COLOUR_BITS-1:0] red_out_o
);

  logic accept;

  assign accept = start_i && !busy_o;

  // back part drains every cycle, so the queue never fills
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  a_point_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (depth_raw_i != '0) |-> ##6 done_o)
    else $error("measured pixel gave no point");

  a_no_point_for_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (depth_raw_i == '0) |-> ##6 !done_o)
    else $error("zero-depth pixel gave a point");

  a_colour_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (blue_out_o == $past(blue_in_i, 6)) && (red_out_o == $past(red_in_i, 6)))
    else $error("colour out of step with point");

endmodule

bind depth_pixel_back_projection dpbp_checker u_dpbp_checker (.*);
`default_nettype wire
